/* design/dnp_pkg.sv */
// Package: constants, character codes, and the parser state and result types
`default_nettype none
package dnp_pkg;

  localparam int unsigned MAX_DIGITS = 8;

  localparam int unsigned MANT_W  = 27;
  localparam int unsigned EXP_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic signed [EXP_W-1:0] EXP_MAX = 8'sd127;
  localparam logic [CNT_W-1:0]        CNT_MAX = 8'd255;

  typedef struct packed {
    logic                     active;
    logic                     negative;
    logic [MANT_W-1:0]        acc;
    logic signed [EXP_W-1:0]  exp;
    logic [CNT_W-1:0]         dcnt;
    logic                     point;
    logic [CNT_W-1:0]         ccnt;
  } num_state_t;

  typedef struct packed {
    logic                     valid_res;
    logic                     negative;
    logic [MANT_W-1:0]        mantissa;
    logic signed [EXP_W-1:0]  decimal_exponent;
    logic [CNT_W-1:0]         consumed_count;
  } num_result_t;

  localparam num_state_t STATE_CLEAR = '{
    active: 1'b0, negative: 1'b0, acc: '0, exp: '0, dcnt: '0, point: 1'b0, ccnt: '0
  };

endpackage : dnp_pkg
`default_nettype wire

/* design/decimal_number_parser.sv */
// Top level: decimal number parser with input stage and result register
// Takes one ASCII character per cycle and returns sign, mantissa, decimal exponent and
// character count when a character ends the number. Each character is held in the input
// register until the result register can take its outcome, which is where a result word
// is presented; a new character is accepted every cycle unless a result word waits for
// out_ready while the input register is occupied. The mantissa keeps the first
// MAX_DIGITS digits;
// value = (-1)^negative * mantissa * 10^decimal_exponent.
`default_nettype none
module decimal_number_parser #(
  parameter int unsigned MAX_DIGITS = dnp_pkg::MAX_DIGITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dnp_pkg::CHAR_W-1:0]         in_char_code,
  input  logic                               in_start_of_number,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_valid_res,
  output logic                               out_negative,
  output logic [dnp_pkg::MANT_W-1:0]         out_mantissa,
  output logic signed [dnp_pkg::EXP_W-1:0]   out_decimal_exponent,
  output logic [dnp_pkg::CNT_W-1:0]          out_consumed_count
);
  import dnp_pkg::*;

  logic                s1_valid_r;
  logic [CHAR_W-1:0]   s1_char_r;
  logic                s1_start_r;
  num_state_t          state_r;
  num_state_t          state_nxt;
  logic                emit;
  num_result_t         res;
  num_result_t         res_r;
  logic                out_valid_r;
  logic                adv;
  logic                fire;

  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  dnp_step #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_step (
    .cur             (state_r),
    .char_code       (s1_char_r),
    .start_of_number (s1_start_r),
    .nxt             (state_nxt),
    .emit            (emit),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_CLEAR;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        state_r     <= state_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r  <= in_char_code;
      s1_start_r <= in_start_of_number;
    end
    if (fire && emit) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_valid_res        = res_r.valid_res;
  assign out_negative         = res_r.negative;
  assign out_mantissa         = res_r.mantissa;
  assign out_decimal_exponent = res_r.decimal_exponent;
  assign out_consumed_count   = res_r.consumed_count;

endmodule : decimal_number_parser
`default_nettype wire

/* design/dnp_step.sv */
// One character step: next parser state and the result word it emits
`default_nettype none
module dnp_step #(
  parameter int unsigned MAX_DIGITS = dnp_pkg::MAX_DIGITS
) (
  input  dnp_pkg::num_state_t           cur,
  input  logic [dnp_pkg::CHAR_W-1:0]    char_code,
  input  logic                          start_of_number,
  output dnp_pkg::num_state_t           nxt,
  output logic                          emit,
  output dnp_pkg::num_result_t          res
);
  import dnp_pkg::*;

  num_state_t              s;
  logic                    is_digit;
  logic                    is_sign;
  logic [MANT_W-1:0]       digit;
  logic [CNT_W-1:0]        dcnt_inc;
  logic [CNT_W-1:0]        ccnt_inc;
  logic                    ok;

  always_comb begin
    s = cur;
    if (start_of_number) begin
      s = STATE_CLEAR;
      s.active = 1'b1;
    end

    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_sign  = (char_code == CH_MINUS) || (char_code == CH_PLUS);
    digit    = MANT_W'(char_code - CH_ZERO);
    dcnt_inc = (s.dcnt == CNT_MAX) ? s.dcnt : s.dcnt + 1'b1;
    ccnt_inc = (s.ccnt == CNT_MAX) ? s.ccnt : s.ccnt + 1'b1;

    nxt  = cur;
    emit = 1'b0;

    if (start_of_number || cur.active) begin
      nxt = s;
      if (start_of_number && is_sign) begin
        nxt.negative = (char_code == CH_MINUS);
        nxt.ccnt     = ccnt_inc;
      end else if (is_digit) begin
        nxt.dcnt = dcnt_inc;
        nxt.ccnt = ccnt_inc;
        if (dcnt_inc <= CNT_W'(MAX_DIGITS)) begin
          if (s.point) begin
            nxt.exp = s.exp - 8'sd1;
          end
          nxt.acc = (s.acc << 3) + (s.acc << 1) + digit;
        end else if (!s.point && (s.exp != EXP_MAX)) begin
          nxt.exp = s.exp + 8'sd1;
        end
      end else if ((char_code == CH_POINT) && !s.point) begin
        nxt.point = 1'b1;
        nxt.ccnt  = ccnt_inc;
      end else begin
        emit       = 1'b1;
        nxt.active = 1'b0;
      end
    end

    ok                   = (s.dcnt != '0);
    res.valid_res        = ok;
    res.negative         = ok && s.negative;
    res.mantissa         = ok ? s.acc : '0;
    res.decimal_exponent = ok ? s.exp : '0;
    res.consumed_count   = s.ccnt;
  end

endmodule : dnp_step
`default_nettype wire

/* design/dnp_checker.sv */
// Port-level checker for the decimal number parser, bound to the top level
`default_nettype none
module dnp_port_checker #(
  parameter int unsigned MAX_DIGITS = dnp_pkg::MAX_DIGITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_ready,
  input  wire                              out_valid,
  input  wire                              out_ready,
  input  wire                              out_valid_res,
  input  wire                              out_negative,
  input  wire [dnp_pkg::MANT_W-1:0]        out_mantissa,
  input  wire signed [dnp_pkg::EXP_W-1:0]  out_decimal_exponent,
  input  wire [dnp_pkg::CNT_W-1:0]         out_consumed_count
);
  import dnp_pkg::*;

  localparam logic signed [EXP_W-1:0] EXP_MIN = -$signed(EXP_W'(MAX_DIGITS));

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mantissa)
      && $stable(out_decimal_exponent) && $stable(out_consumed_count))
    else $error("stalled result word changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");

  a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      !out_negative && (out_mantissa == '0) && (out_decimal_exponent == '0))
    else $error("digitless result carries non-zero fields");

  a_exp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_decimal_exponent >= EXP_MIN)
    else $error("decimal exponent below digit cap");

endmodule : dnp_port_checker

bind decimal_number_parser dnp_port_checker #(
  .MAX_DIGITS (MAX_DIGITS)
) u_dnp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_valid_res        (out_valid_res),
  .out_negative         (out_negative),
  .out_mantissa         (out_mantissa),
  .out_decimal_exponent (out_decimal_exponent),
  .out_consumed_count   (out_consumed_count)
);
`default_nettype wire
